/* rtl/sscs_pkg.sv */
// Shared types, codes and character helpers for the substring search core.
package sscs_pkg;

  localparam logic OP_NEEDLE = 1'b0;
  localparam logic OP_HAY    = 1'b1;

  localparam logic CFG_NEEDLE_LENGTH = 1'b0;
  localparam logic CFG_CASE_MODE     = 1'b1;

  localparam logic MODE_FOLD  = 1'b0;
  localparam logic MODE_SMART = 1'b1;

  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5A;
  localparam logic [7:0] CHAR_LO_A = 8'h61;
  localparam logic [7:0] CHAR_LO_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  localparam int CFG_DATA_W = 7;
  localparam int POS_OUT_W  = 16;

  typedef struct packed {
    logic       is_hay;
    logic       wr_ok;
    logic [5:0] idx;
    logic [7:0] data;
    logic [7:0] fold;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [6:0] needle_length;
    logic       case_mode;
  } cfg_t;

  typedef struct packed {
    logic                 found;
    logic [POS_OUT_W-1:0] pos;
    logic                 ovf;
    logic                 done;
  } res_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
  endfunction

  // h_fold is the haystack byte already folded to upper case
  function automatic logic bytes_match(input logic [7:0] n, input logic [7:0] h,
                                       input logic [7:0] h_fold, input logic mode);
    if (mode == MODE_SMART && is_upper(n)) begin
      return n == h;
    end
    return fold_upper(n) == h_fold;
  endfunction

endpackage

/* rtl/sscs_fifo.sv */
// Small register FIFO used for the item queue and the result queue.
module sscs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q + CW'(do_wr) - CW'(do_rd);
    if (do_wr) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_rd) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

/* rtl/sscs_front.sv */
// Front end: takes input items, classifies them and queues them for the matcher.
module sscs_front import sscs_pkg::*; #(
  parameter int NEEDLE_MAX = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       operation_i,
  input  logic [5:0] needle_index_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       q_pop_i,
  output logic       q_empty_o,
  output item_t      q_item_o
);

  item_t item;

  always_comb begin
    item.is_hay = (operation_i == OP_HAY);
    // writes past the store are flagged here so the back end never stores them
    item.wr_ok  = (operation_i == OP_NEEDLE) && (int'(needle_index_i) < NEEDLE_MAX);
    item.idx    = needle_index_i;
    item.data   = data_byte_i;
    item.fold   = fold_upper(data_byte_i);
    item.last   = last_byte_i;
  end

  sscs_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(2)
  ) u_item_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (push),
    .full_o (full),
    .wdata_i(item),
    .rd_i   (q_pop_i),
    .empty_o(q_empty_o),
    .rdata_o(q_item_o)
  );

endmodule

/* rtl/sscs_back.sv */
// Back end: needle store, shift-and matcher, match bookkeeping and result queue.
module sscs_back import sscs_pkg::*; #(
  parameter int NEEDLE_MAX    = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_empty_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  input  logic  pop,
  output logic  empty,
  output res_t  res_o
);

  localparam int IDX_W  = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
  localparam int LCW    = (7 > $clog2(NEEDLE_MAX + 1)) ? 7 : $clog2(NEEDLE_MAX + 1);
  localparam int CNT_W  = POSITION_BITS + 8;

  logic [7:0]               needle_q [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0]    pmv_q, pmv_d, hit;
  logic [CNT_W-1:0]         cnt_q, cnt_d, start;
  logic [POSITION_BITS-1:0] fstart_q, fstart_d;
  logic                     found_q, found_d, ovf_q, ovf_d;
  logic [LCW-1:0]           lenc;
  logic [IDX_W-1:0]         sel, widx;
  logic                     res_full, take, res_wr;
  res_t                     res;

  assign take    = !q_empty_i && (!q_item_i.is_hay || !res_full);
  assign q_pop_o = take;
  assign res_wr  = take && q_item_i.is_hay;
  assign widx    = IDX_W'(q_item_i.idx);

  assign lenc  = (LCW'(cfg_i.needle_length) > LCW'(NEEDLE_MAX)) ? LCW'(NEEDLE_MAX)
                                                                 : LCW'(cfg_i.needle_length);
  assign sel   = IDX_W'(lenc - LCW'(1));
  assign start = cnt_q - CNT_W'(lenc - LCW'(1));

  always_comb begin
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      hit[i] = bytes_match(needle_q[i], q_item_i.data, q_item_i.fold, cfg_i.case_mode);
    end
    pmv_d[0] = hit[0];
    for (int i = 1; i < NEEDLE_MAX; i++) begin
      pmv_d[i] = pmv_q[i-1] && hit[i];
    end
  end

  always_comb begin
    cnt_d    = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
    found_d  = found_q;
    fstart_d = fstart_q;
    ovf_d    = ovf_q;
    if (!found_q) begin
      if (lenc == '0) begin
        found_d  = 1'b1;
        fstart_d = '0;
      end else if (pmv_d[sel]) begin
        found_d = 1'b1;
        if (|start[CNT_W-1:POSITION_BITS]) begin
          fstart_d = '1;
          ovf_d    = 1'b1;
        end else begin
          fstart_d = start[POSITION_BITS-1:0];
        end
      end
    end
    res.found = found_d;
    res.pos   = POS_OUT_W'(fstart_d);
    res.ovf   = ovf_d;
    res.done  = q_item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmv_q    <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      fstart_q <= '0;
      ovf_q    <= 1'b0;
    end else if (res_wr) begin
      if (q_item_i.last) begin
        pmv_q    <= '0;
        cnt_q    <= '0;
        found_q  <= 1'b0;
        fstart_q <= '0;
        ovf_q    <= 1'b0;
      end else begin
        pmv_q    <= pmv_d;
        cnt_q    <= cnt_d;
        found_q  <= found_d;
        fstart_q <= fstart_d;
        ovf_q    <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && q_item_i.wr_ok) begin
      needle_q[widx] <= q_item_i.data;
    end
  end

  sscs_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_wr),
    .full_o (res_full),
    .wdata_i(res),
    .rd_i   (pop),
    .empty_o(empty),
    .rdata_o(res_o)
  );

endmodule

/* rtl/smart_case_substring_search_core.sv */
// A haystack byte is registered in the item queue, and its result in the result queue.
// Throughput: one item per cycle (shift-and matcher) while the result queue is not full.
// Needle writes take a slot in the item queue but give no result.
// Reset (async, active low) clears both queues, the match state and the config registers;
// the needle store is not cleared and holds garbage until written.
module smart_case_substring_search_core import sscs_pkg::*; #(
  parameter int NEEDLE_MAX    = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  operation_i,
  input  logic [5:0]            needle_index_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  match_found_o,
  output logic [POS_OUT_W-1:0]  match_position_o,
  output logic                  position_overflow_o,
  output logic                  search_done_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t q_item;
  logic  q_empty, q_pop;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NEEDLE_LENGTH: cfg_q.needle_length <= cfg_data_i;
        CFG_CASE_MODE:     cfg_q.case_mode     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sscs_front #(
    .NEEDLE_MAX(NEEDLE_MAX)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .operation_i   (operation_i),
    .needle_index_i(needle_index_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .q_pop_i       (q_pop),
    .q_empty_o     (q_empty),
    .q_item_o      (q_item)
  );

  sscs_back #(
    .NEEDLE_MAX   (NEEDLE_MAX),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_empty_i(q_empty),
    .q_item_i (q_item),
    .q_pop_o  (q_pop),
    .pop      (pop),
    .empty    (empty),
    .res_o    (res)
  );

  assign match_found_o       = res.found;
  assign match_position_o    = res.pos;
  assign position_overflow_o = res.ovf;
  assign search_done_o       = res.done;

endmodule

/* tb/sv/tb_smart_case_substring_search_core.sv */
// Self-checking testbench for the smart-case substring search core.
`timescale 1ns / 100ps

import sscs_pkg::*;

class search_result_tracker;
  logic [7:0]  needle [64];
  logic [63:0] partial;
  logic [23:0] bytes_seen;
  logic        found;
  logic [15:0] found_at;
  logic        ovf;
  logic [6:0]  needle_len;
  logic        mode;
  res_t        reports_due [$];
  int          mismatches;
  int          n_checked;
  int          n_searches;
  int          n_matched;
  int          n_ovf;

  function new();
    foreach (needle[i]) needle[i] = 8'h00;
    needle_len = '0;
    mode = MODE_FOLD;
    mismatches = 0;
    n_checked = 0;
    n_searches = 0;
    n_matched = 0;
    n_ovf = 0;
    clear_search();
  endfunction

  function void clear_search();
    partial = '0;
    bytes_seen = '0;
    found = 1'b0;
    found_at = '0;
    ovf = 1'b0;
  endfunction

  function void set_reg(logic idx, logic [6:0] val);
    if (idx == CFG_NEEDLE_LENGTH) needle_len = val;
    else mode = val[0];
  endfunction

  // uppercase needle letters are exact in smart mode, everything else folds
  function logic char_hit(logic [7:0] n, logic [7:0] h);
    logic [7:0] nu, hu;
    if (mode == MODE_SMART && n >= CHAR_UP_A && n <= CHAR_UP_Z) return n == h;
    nu = (n >= CHAR_LO_A && n <= CHAR_LO_Z) ? n - CASE_GAP : n;
    hu = (h >= CHAR_LO_A && h <= CHAR_LO_Z) ? h - CASE_GAP : h;
    return nu == hu;
  endfunction

  function int pending();
    return reports_due.size();
  endfunction

  function void take_item(logic op, logic [5:0] idx, logic [7:0] data, logic lst);
    int   len;
    int   start;
    logic [23:0] offset;
    res_t want;
    if (op == OP_NEEDLE) begin
      needle[idx] = data;
      return;
    end
    len = (needle_len > 7'd64) ? 64 : int'(needle_len);
    for (int i = 63; i > 0; i--) partial[i] = partial[i-1] && char_hit(needle[i], data);
    partial[0] = char_hit(needle[0], data);
    offset = bytes_seen;
    if (bytes_seen != 24'hFFFFFF) bytes_seen++;
    if (!found) begin
      if (len == 0) begin
        found = 1'b1;
        found_at = '0;
      end else if (partial[len-1]) begin
        start = int'(offset) - len + 1;
        found = 1'b1;
        if (start > 65535) begin
          found_at = 16'hFFFF;
          ovf = 1'b1;
        end else begin
          found_at = 16'(start);
        end
      end
    end
    want.found = found;
    want.pos = found_at;
    want.ovf = ovf;
    want.done = lst;
    reports_due.push_back(want);
    if (lst) begin
      n_searches++;
      if (found) n_matched++;
      if (ovf) n_ovf++;
      clear_search();
    end
  endfunction

  function void compare(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (reports_due.size() == 0) begin
      $display("%0t: result with none expected: found=%0b pos=%0d ovf=%0b done=%0b",
               $time, got.found, got.pos, got.ovf, got.done);
      mismatches++;
      return;
    end
    want = reports_due.pop_front();
    n_checked++;
    compare("match_found", 16'(want.found), 16'(got.found));
    compare("match_position", want.pos, got.pos);
    compare("position_overflow", 16'(want.ovf), 16'(got.ovf));
    compare("search_done", 16'(want.done), 16'(got.done));
  endfunction
endclass

module tb_smart_case_substring_search_core;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int LONG_HOLD    = 80;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic                  operation_i;
  logic [5:0]            needle_index_i;
  logic [7:0]            data_byte_i;
  logic                  last_byte_i;
  logic                  empty;
  logic                  pop;
  logic                  match_found_o;
  logic [POS_OUT_W-1:0]  match_position_o;
  logic                  position_overflow_o;
  logic                  search_done_o;
  logic                  cfg_we_i;
  logic                  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  search_result_tracker sb;
  bit tx_idle;
  bit rx_idle;
  bit hold_req;
  int items_sent;
  int stall_cycles;
  int cycle_count;
  int max_len_seen;

  smart_case_substring_search_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .operation_i        (operation_i),
    .needle_index_i     (needle_index_i),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .empty              (empty),
    .pop                (pop),
    .match_found_o      (match_found_o),
    .match_position_o   (match_position_o),
    .position_overflow_o(position_overflow_o),
    .search_done_o      (search_done_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("smart_case_substring_search_core test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (push && full) stall_cycles++;
  end

  // result side: random pop bursts plus one long hold-off on request
  initial begin : result_side
    int gap_left;
    int hold_left;
    gap_left = 0;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        pop <= 1'b0;
        gap_left--;
      end else begin
        pop <= 1'b1;
        if (rx_idle && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && pop && !empty) begin
      got.found = match_found_o;
      got.pos = match_position_o;
      got.ovf = position_overflow_o;
      got.done = search_done_o;
      sb.check_result(got);
    end
  end

  function automatic logic [7:0] vary_case(logic [7:0] c);
    if (((c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LO_A && c <= CHAR_LO_Z)) &&
        $urandom_range(0, 7) == 0) return c ^ CASE_GAP;
    return c;
  endfunction

  // small letter alphabet so that partial and full matches are frequent
  function automatic logic [7:0] rand_needle_byte();
    if ($urandom_range(0, 3) != 0)
      return (CHAR_UP_A + 8'($urandom_range(0, 3))) | ($urandom_range(0, 1) ? CASE_GAP : 8'h00);
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(logic op, logic [5:0] idx, logic [7:0] data, logic lst);
    int gap;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    operation_i <= op;
    needle_index_i <= idx;
    data_byte_i <= data;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.take_item(op, idx, data, lst);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_hay(logic [7:0] data, logic lst);
    send_item(OP_HAY, 6'($urandom_range(0, 63)), data, lst);
  endtask

  task automatic send_needle(logic [5:0] idx, logic [7:0] data);
    send_item(OP_NEEDLE, idx, data, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_hay(s[i], close && (i == s.len() - 1));
  endtask

  // drain all results, then give needle writes still in flight time to land
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    if (idx == CFG_NEEDLE_LENGTH && int'(val) > max_len_seen) max_len_seen = int'(val);
    @(negedge clk_i);
  endtask

  task automatic random_phase();
    int   r;
    int   len;
    int   eff;
    int   hlen;
    int   epos;
    int   nsearch;
    logic [6:0] mode_val;
    logic [7:0] b;
    logic lst;
    settle();
    r = $urandom_range(0, 19);
    if (r < 2) len = 0;
    else if (r < 14) len = $urandom_range(1, 6);
    else if (r < 17) len = $urandom_range(7, 20);
    else if (r == 17) len = 64;
    else if (r == 18) len = $urandom_range(65, 127);
    else len = $urandom_range(21, 63);
    write_cfg(CFG_NEEDLE_LENGTH, 7'(len));
    mode_val = 7'($urandom_range(0, 127));
    write_cfg(CFG_CASE_MODE, mode_val);
    eff = (len > 64) ? 64 : len;
    for (int i = 0; i < eff; i++) send_needle(6'(i), rand_needle_byte());
    nsearch = $urandom_range(2, 5);
    for (int s = 0; s < nsearch; s++) begin
      hlen = (eff > 20) ? eff + $urandom_range(0, 16) : $urandom_range(1, 30);
      epos = -1;
      for (int k = 0; k < hlen; k++) begin
        if ($urandom_range(0, 39) == 0)
          send_needle(6'($urandom_range(0, 63)), rand_needle_byte());
        if (epos < 0 && eff > 0 && ($urandom_range(0, 4) == 0 || (k == 0 && eff > 20)))
          epos = 0;
        if (epos >= 0) begin
          b = vary_case(sb.needle[epos]);
          epos++;
          if (epos >= eff) epos = -1;
        end else if ($urandom_range(0, 3) == 0) begin
          b = 8'($urandom_range(0, 255));
        end else begin
          b = vary_case(sb.needle[$urandom_range(0, ((eff > 0) ? eff : 4) - 1)]);
        end
        // now and then a search runs on into the next one
        lst = (k == hlen - 1) && ($urandom_range(0, 7) != 0);
        send_hay(b, lst);
      end
    end
  endtask

  initial begin : stimulus
    int base;
    int phase_no;
    sb = new();
    rst_ni = 1'b0;
    push = 1'b0;
    operation_i = OP_NEEDLE;
    needle_index_i = '0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_NEEDLE_LENGTH;
    cfg_data_i = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    items_sent = 0;
    stall_cycles = 0;
    max_len_seen = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill every needle slot so that any length reads written data
    for (int i = 0; i < 64; i++) send_needle(6'(i), rand_needle_byte());

    // empty needle after reset: match at offset zero
    send_hay(8'h00, 1'b0);
    send_hay(8'hFF, 1'b1);

    settle();
    write_cfg(CFG_NEEDLE_LENGTH, 7'd3);
    write_cfg(CFG_CASE_MODE, {6'd0, MODE_FOLD});
    send_needle(6'd0, "A");
    send_needle(6'd1, "b");
    send_needle(6'd2, "Z");
    // bytes just outside the letter ranges must not fold
    send_text("@[aBz`{", 1'b1);

    settle();
    write_cfg(CFG_CASE_MODE, 7'h7F);
    // lowercase right after a mismatch must not hit an uppercase first byte
    send_text("XabZAbzABZ", 1'b1);
    // needle rewritten while the search is running
    send_hay("A", 1'b0);
    send_needle(6'd2, "q");
    send_text("bQ", 1'b1);

    settle();
    write_cfg(CFG_NEEDLE_LENGTH, 7'd127);
    write_cfg(CFG_CASE_MODE, {6'd0, MODE_FOLD});
    send_hay(8'h41, 1'b0);
    send_hay(8'h7A, 1'b1);

    base = items_sent;
    phase_no = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      random_phase();
      phase_no++;
      if (phase_no == 3) begin
        // long hold-off on the result side while the input keeps pushing
        hold_req = 1'b1;
        tx_idle = 1'b0;
        repeat (40) send_hay(8'($urandom_range(0, 255)), 1'($urandom_range(0, 9) == 0));
        tx_idle = 1'b1;
      end
    end

    // closing stretch back to back, no idling on either side
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    settle();
    write_cfg(CFG_NEEDLE_LENGTH, 7'd3);
    write_cfg(CFG_CASE_MODE, {6'd0, MODE_SMART});
    send_needle(6'd0, "X");
    send_needle(6'd1, "y");
    send_needle(6'd2, "Z");
    repeat (20) send_hay(".", 1'b0);
    send_text("XYZ.", 1'b1);
    repeat (20) send_hay(".", 1'b0);
    send_text("XyZXyZ.", 1'b1);
    send_text("xYZ", 1'b1);

    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Checked %0d results over %0d closed searches: %0d matched, %0d overflowed.",
             sb.n_checked, sb.n_searches, sb.n_matched, sb.n_ovf);
    $display("Needle lengths up to %0d, both case modes; input held off %0d cycles, %0d cycles.",
             max_len_seen, stall_cycles, cycle_count);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("smart_case_substring_search_core test passed");
    end else begin
      $display("smart_case_substring_search_core test failed");
    end
    $finish;
  end

endmodule
